// ===== rtl/core/ypc_pkg.sv =====
// Package for the YMODEM packet classifier: control codes, packet type
// encoding, result struct and the byte-wide CRC-16 update.
// No dependencies.
package ypc_pkg;

  // Control characters seen at the head of a packet
  localparam logic [7:0] CODE_SOH = 8'h01;
  localparam logic [7:0] CODE_STX = 8'h02;
  localparam logic [7:0] CODE_EOT = 8'h04;
  localparam logic [7:0] CODE_ACK = 8'h06;
  localparam logic [7:0] CODE_NAK = 8'h15;
  localparam logic [7:0] CODE_CAN = 8'h18;
  localparam logic [7:0] CODE_REQ = 8'h43;

  // CRC-16 polynomial (x^16 + x^12 + x^5 + 1), MSB first
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // Block number plus its complement must give this
  localparam logic [8:0] BLOCK_SUM = 9'h0ff;

  typedef enum logic [2:0] {
    PKT_INVALID = 3'd0,
    PKT_SOH     = 3'd1,
    PKT_STX     = 3'd2,
    PKT_EOT     = 3'd3,
    PKT_ACK     = 3'd4,
    PKT_NAK     = 3'd5,
    PKT_CAN     = 3'd6,
    PKT_REQ     = 3'd7
  } pkt_type_t;

  typedef struct packed {
    pkt_type_t  packet_type;
    logic [7:0] block_number;
  } ypc_result_t;

  // One byte into the CRC, eight shift steps unrolled
  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in,
                                           input logic [7:0]  data);
    logic [15:0] crc;
    crc = crc_in ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (crc[15]) begin
        crc = {crc[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        crc = {crc[14:0], 1'b0};
      end
    end
    return crc;
  endfunction

  // Packet type of a command packet from its lead byte
  function automatic pkt_type_t command_type(input logic [7:0] c);
    pkt_type_t t;
    case (c)
      CODE_EOT: t = PKT_EOT;
      CODE_ACK: t = PKT_ACK;
      CODE_NAK: t = PKT_NAK;
      CODE_CAN: t = PKT_CAN;
      CODE_REQ: t = PKT_REQ;
      default:  t = PKT_INVALID;
    endcase
    return t;
  endfunction

endpackage

// ===== rtl/core/ypc_classify.sv =====
// Per-packet tracking state and classification logic of the YMODEM
// packet classifier. Depends on ypc_pkg.
module ypc_classify import ypc_pkg::*; #(
  parameter int COMMAND_LIMIT = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        byte_fire,   // registered byte is consumed this cycle
  input  logic [7:0]  rx_byte,
  input  logic        last_byte,
  output ypc_result_t result       // valid when byte_fire && last_byte
);

  localparam int CW = $clog2(COMMAND_LIMIT + 1);
  localparam logic [CW-1:0] CNT_MAX   = CW'(COMMAND_LIMIT);
  localparam logic [CW-1:0] CNT_SHORT = CW'(COMMAND_LIMIT - 1);
  localparam logic [CW-1:0] POS_BLK   = CW'(1);
  localparam logic [CW-1:0] POS_CMP   = CW'(2);
  localparam logic [CW-1:0] POS_CRC   = CW'(5);

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [7:0]    lead_r, lead_nxt;
  logic [7:0]    blk_r, blk_nxt;
  logic [7:0]    cmp_r, cmp_nxt;
  logic          eq_r, eq_nxt;
  logic [15:0]   crc_r, crc_nxt;
  logic [7:0]    old_r, old_nxt;
  logic [7:0]    new_r, new_nxt;

  logic          first;
  logic [7:0]    lead;
  logic          eq_now;
  logic [15:0]   crc_fed;
  logic          data_ok;

  // Shared terms
  always_comb begin
    first   = (cnt_r == '0);
    lead    = first ? rx_byte : lead_r;
    eq_now  = eq_r & (first | (rx_byte == lead));
    crc_fed = crc_feed(crc_r, old_r);
    data_ok = (crc_fed == {new_r, rx_byte}) &&
              (({1'b0, blk_r} + {1'b0, cmp_r}) == BLOCK_SUM);
  end

  // Classification on the last byte
  always_comb begin
    result.packet_type  = PKT_INVALID;
    result.block_number = 8'h00;
    if (cnt_r < CNT_SHORT) begin
      if (eq_now) begin
        result.packet_type = command_type(lead);
      end
    end else if ((lead == CODE_SOH || lead == CODE_STX) && data_ok) begin
      result.packet_type  = (lead == CODE_SOH) ? PKT_SOH : PKT_STX;
      result.block_number = blk_r;
    end
  end

  // State update: header capture, delay line and CRC, or clear at packet end
  always_comb begin
    cnt_nxt  = cnt_r;
    lead_nxt = lead_r;
    blk_nxt  = blk_r;
    cmp_nxt  = cmp_r;
    eq_nxt   = eq_r;
    crc_nxt  = crc_r;
    old_nxt  = old_r;
    new_nxt  = new_r;
    if (byte_fire) begin
      if (last_byte) begin
        cnt_nxt  = '0;
        lead_nxt = 8'h00;
        blk_nxt  = 8'h00;
        cmp_nxt  = 8'h00;
        eq_nxt   = 1'b1;
        crc_nxt  = 16'h0000;
        old_nxt  = 8'h00;
        new_nxt  = 8'h00;
      end else begin
        eq_nxt = eq_now;
        if (first) begin
          lead_nxt = rx_byte;
        end else if (cnt_r == POS_BLK) begin
          blk_nxt = rx_byte;
        end else if (cnt_r == POS_CMP) begin
          cmp_nxt = rx_byte;
        end else begin
          if (cnt_r >= POS_CRC) begin
            crc_nxt = crc_fed;
          end
          old_nxt = new_r;
          new_nxt = rx_byte;
        end
        if (cnt_r < CNT_MAX) begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      lead_r <= 8'h00;
      blk_r  <= 8'h00;
      cmp_r  <= 8'h00;
      eq_r   <= 1'b1;
      crc_r  <= 16'h0000;
      old_r  <= 8'h00;
      new_r  <= 8'h00;
    end else begin
      cnt_r  <= cnt_nxt;
      lead_r <= lead_nxt;
      blk_r  <= blk_nxt;
      cmp_r  <= cmp_nxt;
      eq_r   <= eq_nxt;
      crc_r  <= crc_nxt;
      old_r  <= old_nxt;
      new_r  <= new_nxt;
    end
  end

endmodule

// ===== rtl/core/ymodem_packet_classifier.sv =====
// A result reaches out_* from the accepted request carrying the last byte
// through the input register, then the result register.
// Throughput: one byte per cycle while not stalled; CRC: one unrolled byte step.
// in_tready drops only while a result waits in the result register and the
// registered byte is a last byte. Reset (rst_n low, synchronous) empties
// both registers and returns the packet state to the start of a packet.
// Top level of the YMODEM packet classifier. Depends on ypc_pkg, ypc_classify.
module ymodem_packet_classifier import ypc_pkg::*; #(
  parameter int COMMAND_LIMIT = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [2:0] packet_type, [10:3] block_number, zero fill
);

  logic        s1_valid_r, s1_valid_nxt;
  logic [7:0]  s1_byte_r;
  logic        s1_last_r;
  logic        s1_advance;
  logic        s1_fire;
  logic        out_valid_r, out_valid_nxt;
  ypc_result_t out_res_r;
  ypc_result_t res;

  // Handshake: a byte leaves stage 1 unless it is a last byte facing a full,
  // stalled result register
  always_comb begin
    s1_advance   = !s1_last_r || !out_valid_r || out_tready;
    s1_fire      = s1_valid_r && s1_advance;
    in_tready    = !s1_valid_r || s1_advance;
    s1_valid_nxt = (in_tvalid && in_tready) || (s1_valid_r && !s1_advance);
    if (s1_fire && s1_last_r) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
    if (in_tvalid && in_tready) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  ypc_classify #(
    .COMMAND_LIMIT (COMMAND_LIMIT)
  ) u_classify (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_fire (s1_fire),
    .rx_byte   (s1_byte_r),
    .last_byte (s1_last_r),
    .result    (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (s1_fire && s1_last_r) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b00000, out_res_r.block_number, out_res_r.packet_type};

`ifndef ASSERT_OFF
  // Stage 1 only stalls behind a full, stalled result register
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled without a pending result");

  // A new result only follows a last byte leaving stage 1
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(s1_valid_r && s1_last_r))
    else $error("result without a last byte");

  // Only data packets carry a block number
  a_blk_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_res_r.block_number != 8'h00) |->
      (out_res_r.packet_type == PKT_SOH || out_res_r.packet_type == PKT_STX))
    else $error("block number on a command packet");
`endif

endmodule
